@@ rtl/srs_pkg.sv @@
// shared types and constants for the substring replace stream core
`timescale 1ns / 1ps

package srs_pkg;

	localparam int unsigned DEF_MAX_SEARCH_LEN  = 8;
	localparam int unsigned DEF_MAX_REPLACE_LEN = 8;
	localparam int unsigned PACKED_BYTES        = 8;
	localparam int unsigned CFG_W               = 64;
	localparam int unsigned BYTE_IDX_W          = 3;
	localparam int unsigned CNT_W               = 4;

	// register map of the write port
	typedef enum logic [1:0] {
		REG_SEARCH_PATTERN     = 2'd0,
		REG_SEARCH_LENGTH      = 2'd1,
		REG_REPLACEMENT_TEXT   = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} reg_index_t;

	// output sequencer
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_REPL,
		SEQ_FLUSH,
		SEQ_END
	} seq_state_t;

	// what every window cell does at the next edge
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_SHIFT_EFF,
		CELL_SHIFT_HELD
	} cell_op_t;

	// what a cell shows to its neighbour and to the control
	typedef struct packed {
		logic [7:0] eff;
		logic [7:0] held;
		logic       hit;
	} cell_view_t;

endpackage

@@ rtl/srs_in_if.sv @@
// input channel: one text byte per transfer
`timescale 1ns / 1ps

interface srs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

@@ rtl/srs_out_if.sv @@
// output channel: one text byte or end marker per transfer
`timescale 1ns / 1ps

interface srs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       end_marker;

	modport source (output valid, output out_byte, output end_marker, input ready);
	modport sink (input valid, input out_byte, input end_marker, output ready);
endinterface

@@ rtl/srs_cell.sv @@
// one window cell: holds a byte, compares it with its pattern byte, shifts
`timescale 1ns / 1ps

module srs_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned FW  = 4
) (
	input  logic               clk,
	input  srs_pkg::cell_op_t  op,
	input  logic [FW-1:0]      fill,
	input  logic [FW-1:0]      len,
	input  logic [7:0]         new_byte,
	input  logic [7:0]         pat_byte,
	input  srs_pkg::cell_view_t next_view,
	output srs_pkg::cell_view_t view
);
	import srs_pkg::*;

	logic [7:0] byte_q;
	logic [7:0] eff;

	// the incoming byte lands in the cell at the fill position
	assign eff = (fill == FW'(IDX)) ? new_byte : byte_q;

	assign view.eff  = eff;
	assign view.held = byte_q;
	// cells beyond the pattern length always agree
	assign view.hit  = (FW'(IDX) >= len) || (eff == pat_byte);

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_HOLD:       byte_q <= byte_q;
			CELL_LOAD:       byte_q <= eff;
			CELL_SHIFT_EFF:  byte_q <= next_view.eff;
			CELL_SHIFT_HELD: byte_q <= next_view.held;
		endcase
	end

endmodule

@@ rtl/substring_replace_stream_core.sv @@
// top level of the streaming find and replace core
`timescale 1ns / 1ps

// Streaming find and replace over a byte text. Every occurrence of the search
// pattern (1 to 8 bytes, first character in bits 7:0) is replaced by the
// replacement text (0 to 8 bytes); matching is greedy, left to right and
// non-overlapping. The window is a row of cells, one byte each; every cell
// compares its byte with its pattern byte and hands its byte to the left
// neighbour when the oldest byte leaves. A byte that completes no match
// yields at most one output byte, so while the output is not stalled a
// text streams at one byte per cycle. A match holds the input while the
// replacement bytes beyond the first leave. The final byte (in_last) flushes
// the window one byte per cycle while the output is not stalled and then
// emits the end marker. The rates are set by the single output register,
// which moves one result per transfer. Writing the search length discards
// the window contents; write the registers only while the core is idle.
module substring_replace_stream_core #(
	parameter int unsigned MAX_SEARCH_LEN  = srs_pkg::DEF_MAX_SEARCH_LEN,
	parameter int unsigned MAX_REPLACE_LEN = srs_pkg::DEF_MAX_REPLACE_LEN
) (
	input  logic                       clk,
	input  logic                       arst_n,
	srs_in_if.sink                     text,
	srs_out_if.source                  result,
	input  logic                       wr_en,
	input  srs_pkg::reg_index_t        wr_index,
	input  logic [srs_pkg::CFG_W-1:0]  wr_data
);
	import srs_pkg::*;

	// number of cells and replacement bytes actually usable
	localparam int unsigned CELLS = (MAX_SEARCH_LEN < PACKED_BYTES) ?
		MAX_SEARCH_LEN : PACKED_BYTES;
	localparam int unsigned RCAP  = (MAX_REPLACE_LEN < PACKED_BYTES) ?
		MAX_REPLACE_LEN : PACKED_BYTES;
	localparam int unsigned FW    = $clog2(CELLS + 1);
	localparam int unsigned RW    = $clog2(RCAP + 1);

	// configuration registers
	logic [CFG_W-1:0]      pat_q;
	logic [CFG_W-1:0]      rep_q;
	logic [FW-1:0]         len_q;
	logic [RW-1:0]         rlen_q;
	logic [3:0]            wr_len4;

	// window and sequencer state
	logic [FW-1:0]         fill_q;
	logic [FW-1:0]         fill_d;
	seq_state_t            state_q;
	seq_state_t            state_d;
	logic [BYTE_IDX_W-1:0] ridx_q;
	logic [BYTE_IDX_W-1:0] ridx_d;
	logic                  last_q;
	logic                  last_d;

	// output register
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_end_q;

	logic                  out_free;
	logic                  take;
	logic                  emit;
	logic [7:0]            emit_byte;
	logic                  emit_end;
	cell_op_t              cell_op;

	cell_view_t            views [CELLS+1];
	logic [CELLS-1:0]      hit_vec;
	logic [7:0]            rep_bytes [PACKED_BYTES];
	logic [FW:0]           fill_inc;
	logic                  full;
	logic                  match;
	logic                  fill_zero;
	logic                  rlen_zero;
	logic                  rlen_one;
	logic                  repl_done;

	// handshakes: input moves only when the output register can take a result
	assign out_free = !out_valid_q || result.ready;
	assign text.ready = (state_q == SEQ_IDLE) && out_free;
	assign take = text.valid && text.ready;

	assign result.valid      = out_valid_q;
	assign result.out_byte   = out_byte_q;
	assign result.end_marker = out_end_q;

	// row of window cells, the far end sees an empty neighbour
	assign views[CELLS] = '0;

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		srs_cell #(
			.IDX (k),
			.FW  (FW)
		) u_cell (
			.clk       (clk),
			.op        (cell_op),
			.fill      (fill_q),
			.len       (len_q),
			.new_byte  (text.in_byte),
			.pat_byte  (pat_q[8*k +: 8]),
			.next_view (views[k+1]),
			.view      (views[k])
		);
		assign hit_vec[k] = views[k].hit;
	end

	for (genvar k = 0; k < PACKED_BYTES; k++) begin : g_rep
		assign rep_bytes[k] = rep_q[8*k +: 8];
	end

	// window full after this byte, and all cells agree with the pattern
	assign fill_inc  = (FW+1)'(fill_q) + (FW+1)'(1);
	assign full      = fill_inc == (FW+1)'(len_q);
	assign match     = full && (&hit_vec);
	assign fill_zero = fill_q == '0;
	assign rlen_zero = rlen_q == '0;
	assign rlen_one  = rlen_q == RW'(1);
	assign repl_done = (CNT_W'(ridx_q) + CNT_W'(1)) == CNT_W'(rlen_q);

	// next state of the sequencer
	always_comb begin
		state_d = state_q;
		ridx_d  = ridx_q;
		last_d  = last_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (take) begin
					last_d = text.in_last;
					if (match) begin
						// first replacement byte leaves at once
						if (!rlen_zero && !rlen_one) begin
							state_d = SEQ_REPL;
							ridx_d  = BYTE_IDX_W'(1);
						end else if (rlen_one && text.in_last) begin
							state_d = SEQ_END;
						end
					end else if (full) begin
						if (text.in_last) begin
							state_d = fill_zero ? SEQ_END : SEQ_FLUSH;
						end
					end else if (text.in_last) begin
						state_d = SEQ_FLUSH;
					end
				end
			end
			SEQ_REPL: begin
				if (out_free) begin
					ridx_d = ridx_q + BYTE_IDX_W'(1);
					if (repl_done) begin
						state_d = last_q ? SEQ_END : SEQ_IDLE;
					end
				end
			end
			SEQ_FLUSH: begin
				if (out_free && (fill_q == FW'(1))) begin
					state_d = SEQ_END;
				end
			end
			SEQ_END: begin
				if (out_free) begin
					state_d = SEQ_IDLE;
				end
			end
		endcase
	end

	// results, window operation and fill count
	always_comb begin
		emit      = 1'b0;
		emit_byte = '0;
		emit_end  = 1'b0;
		cell_op   = CELL_HOLD;
		fill_d    = fill_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (take) begin
					if (match) begin
						// window cleared, replacement starts
						fill_d = '0;
						if (!rlen_zero) begin
							emit      = 1'b1;
							emit_byte = rep_bytes[0];
						end else if (text.in_last) begin
							emit     = 1'b1;
							emit_end = 1'b1;
						end
					end else if (full) begin
						// oldest byte leaves, the rest moves up
						cell_op   = CELL_SHIFT_EFF;
						emit      = 1'b1;
						emit_byte = views[0].eff;
					end else begin
						cell_op = CELL_LOAD;
						fill_d  = fill_q + FW'(1);
					end
				end
			end
			SEQ_REPL: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_byte = rep_bytes[ridx_q];
				end
			end
			SEQ_FLUSH: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_byte = views[0].held;
					cell_op   = CELL_SHIFT_HELD;
					fill_d    = fill_q - FW'(1);
				end
			end
			SEQ_END: begin
				if (out_free) begin
					emit     = 1'b1;
					emit_end = 1'b1;
				end
			end
		endcase
	end

	assign wr_len4 = wr_data[3:0];

	// control and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			fill_q      <= '0;
			ridx_q      <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			pat_q       <= '0;
			rep_q       <= '0;
			len_q       <= FW'(1);
			rlen_q      <= '0;
		end else begin
			state_q <= state_d;
			ridx_q  <= ridx_d;
			last_q  <= last_d;
			if (out_free) begin
				out_valid_q <= emit;
			end
			// a new search length discards the window
			if (wr_en && (wr_index == REG_SEARCH_LENGTH)) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_d;
			end
			if (wr_en) begin
				unique case (wr_index)
					REG_SEARCH_PATTERN: pat_q <= wr_data;
					REG_SEARCH_LENGTH: begin
						// empty pattern counts as one byte, long ones saturate
						if (wr_len4 == 4'd0) begin
							len_q <= FW'(1);
						end else if (32'(wr_len4) > CELLS) begin
							len_q <= FW'(CELLS);
						end else begin
							len_q <= FW'(wr_len4);
						end
					end
					REG_REPLACEMENT_TEXT: rep_q <= wr_data;
					REG_REPLACEMENT_LENGTH: begin
						if (32'(wr_len4) > RCAP) begin
							rlen_q <= RW'(RCAP);
						end else begin
							rlen_q <= RW'(wr_len4);
						end
					end
				endcase
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			out_byte_q <= emit_byte;
			out_end_q  <= emit_end;
		end
	end

endmodule

@@ rtl/srs_checker.sv @@
// port-level checks for the substring replace stream core, bound to the top
`timescale 1ns / 1ps

module srs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       text_valid,
	input logic       text_ready,
	input logic       text_last,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] result_byte,
	input logic       result_end
);

	// a stalled result keeps its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(result_byte) && $stable(result_end))
		else $error("stalled result changed");

	// an end marker carries no character
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_end |-> result_byte == 8'd0)
		else $error("end marker with non-zero byte");

	// input is only offered when the output register can move
	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		text_ready |-> !result_valid || result_ready)
		else $error("input ready while output blocked");

	// after the final byte the core takes nothing new until the end marker shows
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_ready && text_last |=>
			!text_ready || (result_valid && result_end))
		else $error("input ready after final byte without end marker");

endmodule

bind substring_replace_stream_core srs_checker u_srs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.text_valid   (text.valid),
	.text_ready   (text.ready),
	.text_last    (text.in_last),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_byte  (result.out_byte),
	.result_end   (result.end_marker)
);

@@ tb/tb_substring_replace_stream_core.sv @@
// self-checking testbench for the streaming find and replace core
`timescale 1ns / 1ps

// one result transfer as the core should produce it
typedef struct packed {
	logic [7:0] ch;
	logic       eot;
} text_result_t;

// scoreboard: mirrors the registers and the match window, keeps the results still owed
class text_replace_predictor;
	logic [63:0]  pattern;
	logic [3:0]   pat_len_reg;
	logic [63:0]  repl_text;
	logic [3:0]   repl_len_reg;
	logic [7:0]   window [8];
	int unsigned  fill;
	text_result_t expected_out[$];
	int unsigned  n_errors;
	int unsigned  n_checked;
	int unsigned  n_matches;

	function new();
		pattern      = '0;
		pat_len_reg  = 4'd1;
		repl_text    = '0;
		repl_len_reg = 4'd0;
		fill         = 0;
		n_errors     = 0;
		n_checked    = 0;
		n_matches    = 0;
	endfunction

	function int unsigned clamp_len(logic [3:0] v, int unsigned lo);
		if (v < lo)
			return lo;
		if (v > 8)
			return 8;
		return v;
	endfunction

	function void set_reg(srs_pkg::reg_index_t idx, logic [63:0] d);
		case (idx)
			srs_pkg::REG_SEARCH_PATTERN: pattern = d;
			srs_pkg::REG_SEARCH_LENGTH: begin
				pat_len_reg = d[3:0];
				fill        = 0;
			end
			srs_pkg::REG_REPLACEMENT_TEXT: repl_text = d;
			srs_pkg::REG_REPLACEMENT_LENGTH: repl_len_reg = d[3:0];
			default: ;
		endcase
	endfunction

	function void owe(logic [7:0] ch, logic eot);
		text_result_t r;
		r.ch  = ch;
		r.eot = eot;
		expected_out.push_back(r);
	endfunction

	function void note_text_byte(logic [7:0] b, logic last);
		int unsigned len;
		int unsigned rlen;
		bit          hit;
		len  = clamp_len(pat_len_reg, 1);
		rlen = clamp_len(repl_len_reg, 0);
		if (fill >= len)
			fill = 0;
		window[fill] = b;
		fill++;
		if (fill == len) begin
			hit = 1'b1;
			for (int k = 0; k < len; k++)
				if (window[k] != pattern[k*8 +: 8])
					hit = 1'b0;
			if (hit) begin
				n_matches++;
				for (int k = 0; k < rlen; k++)
					owe(repl_text[k*8 +: 8], 1'b0);
				fill = 0;
			end else begin
				owe(window[0], 1'b0);
				for (int k = 1; k < len; k++)
					window[k-1] = window[k];
				fill--;
			end
		end
		if (last) begin
			for (int k = 0; k < fill; k++)
				owe(window[k], 1'b0);
			fill = 0;
			owe(8'h00, 1'b1);
		end
	endfunction

	function void check_result(logic [7:0] b, logic eot);
		text_result_t want;
		n_checked++;
		if (expected_out.size() == 0) begin
			n_errors++;
			$error("unexpected result: out_byte %h end_marker %b", b, eot);
			return;
		end
		want = expected_out.pop_front();
		if (b !== want.ch) begin
			n_errors++;
			$error("out_byte: expected %h, actual %h", want.ch, b);
		end
		if (eot !== want.eot) begin
			n_errors++;
			$error("end_marker: expected %b, actual %b", want.eot, eot);
		end
	endfunction

	function int unsigned pending();
		return expected_out.size();
	endfunction
endclass

module tb_substring_replace_stream_core;
	import srs_pkg::*;

	localparam int unsigned N_ITEMS        = 350;
	localparam int unsigned QUIET_FROM     = 300;  // no idling beyond this many bytes
	localparam int unsigned HOLD_FROM      = 120;
	localparam int unsigned HOLD_CYCLES    = 200;
	localparam int unsigned SETTLE_CYCLES  = 12;   // extra settling once every owed result has arrived
	localparam int unsigned WATCHDOG_LIMIT = 4000;

	logic                clk;
	logic                arst_n;
	logic                wr_en;
	reg_index_t          wr_index;
	logic [CFG_W-1:0]    wr_data;

	srs_in_if  text_ch ();
	srs_out_if res_ch ();

	substring_replace_stream_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text_ch),
		.result   (res_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	text_replace_predictor replace_model;

	int unsigned items_sent;
	int unsigned settings_used;
	int unsigned idle_cycles;
	bit          in_idle_on;
	bit          out_idle_on;
	bit          hold_req;
	bit          hold_done;

	// pattern of the current setting, for building texts that hit it
	logic [7:0]  cur_pat [8];
	int unsigned cur_len;
	logic [7:0]  alpha_base;
	logic [7:0]  text_buf[$];

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// every transfer and register write is seen here at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_en)
				replace_model.set_reg(wr_index, wr_data);
			if (res_ch.valid && res_ch.ready)
				replace_model.check_result(res_ch.out_byte, res_ch.end_marker);
			if (text_ch.valid && text_ch.ready)
				replace_model.note_text_byte(text_ch.in_byte, text_ch.in_last);
		end
	end

	// watchdog: too long without any transfer means the core has hung
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((text_ch.valid && text_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off so the core backs up
	initial begin
		res_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				res_ch.ready <= 1'b1;
			end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// one text byte; valid stays high afterwards so back-to-back bytes need no gap
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (in_idle_on && $urandom_range(0, 3) == 0) begin
			text_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		text_ch.valid   <= 1'b1;
		text_ch.in_byte <= b;
		text_ch.in_last <= last;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_buf(input bit mark_last);
		for (int i = 0; i < text_buf.size(); i++)
			send_byte(text_buf[i], mark_last && (i == text_buf.size() - 1));
		text_buf.delete();
	endtask

	// stop offering, wait for every owed result, then let the core settle
	task automatic end_phase();
		text_ch.valid <= 1'b0;
		while (replace_model.pending() != 0)
			@(posedge clk);
		@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// leaves wr_en high, so a run of writes needs no gap; the caller lowers it
	task automatic write_reg(input reg_index_t idx, input logic [63:0] d);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= d;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [63:0] pat, input logic [63:0] slen,
			input logic [63:0] rtext, input logic [63:0] rlen);
		write_reg(REG_SEARCH_PATTERN, pat);
		write_reg(REG_SEARCH_LENGTH, slen);
		write_reg(REG_REPLACEMENT_TEXT, rtext);
		write_reg(REG_REPLACEMENT_LENGTH, rlen);
		wr_en <= 1'b0;
		settings_used++;
	endtask

	// random setting: short patterns mostly, now and then the out-of-range lengths
	task automatic random_setup();
		int unsigned sel;
		logic [3:0]  slen;
		logic [3:0]  rlen;
		logic [63:0] pat;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			slen = 4'd0;
		else if (sel == 1)
			slen = 4'($urandom_range(9, 15));
		else if (sel < 12)
			slen = 4'($urandom_range(1, 3));
		else
			slen = 4'($urandom_range(4, 8));
		cur_len = (slen == 0) ? 1 : (slen > 8) ? 8 : slen;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			rlen = 4'd0;
		else if (sel == 1)
			rlen = 4'($urandom_range(9, 15));
		else
			rlen = 4'($urandom_range(1, 8));
		// small alphabet so that patterns turn up often; bytes past the length are junk
		alpha_base = 8'($urandom_range(0, 252));
		for (int k = 0; k < 8; k++) begin
			if (k < cur_len)
				cur_pat[k] = alpha_base + 8'($urandom_range(0, 3));
			else
				cur_pat[k] = 8'($urandom_range(0, 255));
			pat[k*8 +: 8] = cur_pat[k];
		end
		// upper bits of the length writes carry noise, only the low nibble counts
		set_config(pat, {$urandom, 4'($urandom_range(0, 15)), 24'h0, slen},
			{$urandom, $urandom}, {$urandom, 28'h0, rlen});
	endtask

	// a text mostly of whole patterns, with partial patterns and noise between
	task automatic build_text();
		int unsigned sel;
		int unsigned plen;
		repeat ($urandom_range(1, 8)) begin
			sel = $urandom_range(0, 9);
			if (sel < 5) begin
				for (int k = 0; k < cur_len; k++)
					text_buf.push_back(cur_pat[k]);
			end else if (sel < 7) begin
				plen = $urandom_range(1, cur_len);
				for (int k = 0; k < plen; k++)
					text_buf.push_back(cur_pat[k]);
			end else if (sel < 9) begin
				text_buf.push_back(alpha_base + 8'($urandom_range(0, 3)));
			end else begin
				text_buf.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		replace_model = new();
		items_sent    = 0;
		settings_used = 1;
		in_idle_on    = 1'b1;
		out_idle_on   = 1'b1;
		hold_req      = 1'b0;
		hold_done     = 1'b0;
		arst_n        = 1'b0;
		wr_en         = 1'b0;
		wr_index      = REG_SEARCH_PATTERN;
		wr_data       = '0;
		text_ch.valid   = 1'b0;
		text_ch.in_byte = 8'h00;
		text_ch.in_last = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset setting: single zero byte pattern, empty replacement, so zeros vanish
		text_buf = '{8'h00, 8'hff, 8'h00};
		send_buf(1'b1);
		end_phase();

		// three byte pattern with junk above it, full eight byte replacement;
		// a leading mismatch, one hit, then a partial pattern left for the flush
		set_config(64'ha5c3_5a3c_9e63_6261, 64'd3, 64'hf1e2_d3c4_b5a6_9788, 64'd8);
		text_buf = '{8'h78, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62};
		send_buf(1'b1);
		end_phase();

		// oversized lengths saturate to eight; a hit on the last byte gives
		// eight replacement bytes plus the end marker in one go
		set_config(64'hffff_ffff_ffff_ffff, 64'd15, 64'h0011_2233_4455_6677, 64'd12);
		text_buf = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
		send_buf(1'b1);
		end_phase();

		// search length rewritten mid-text: the three held bytes are dropped;
		// zero length then acts as one and the empty replacement deletes hits
		set_config(64'h0000_0000_0043_4241, 64'd8, 64'h0, 64'd0);
		text_buf = '{8'h41, 8'h42, 8'h43};
		send_buf(1'b0);
		end_phase();
		write_reg(REG_SEARCH_LENGTH, 64'd0);
		wr_en <= 1'b0;
		settings_used++;
		text_buf = '{8'h41, 8'h80};
		send_buf(1'b1);
		end_phase();

		// random settings, one to three texts each
		while (items_sent < N_ITEMS) begin
			random_setup();
			repeat ($urandom_range(1, 3)) begin
				in_idle_on  = (items_sent < QUIET_FROM) && ($urandom_range(0, 9) < 7);
				out_idle_on = (items_sent < QUIET_FROM) && ($urandom_range(0, 9) < 7);
				if (!hold_done && items_sent >= HOLD_FROM) begin
					hold_req  = 1'b1;
					hold_done = 1'b1;
				end
				build_text();
				send_buf(1'b1);
			end
			end_phase();
		end

		if (replace_model.pending() != 0) begin
			replace_model.n_errors++;
			$error("%0d results never arrived", replace_model.pending());
		end
		$display("%0d text bytes over %0d register settings, %0d results checked",
			items_sent, settings_used, replace_model.n_checked);
		$display("%0d pattern hits replaced, one output hold-off of %0d cycles",
			replace_model.n_matches, HOLD_CYCLES);
		if (replace_model.n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

@@ sim.f @@
rtl/srs_pkg.sv
rtl/srs_in_if.sv
rtl/srs_out_if.sv
rtl/srs_cell.sv
rtl/substring_replace_stream_core.sv
rtl/srs_checker.sv
tb/tb_substring_replace_stream_core.sv
